### rtl/rhd_pkg.sv
// rhd_pkg: shared types and constants for the readable hex64 decoder
// depends on nothing; imported by rhd_classify, rhd_core and the top level
package rhd_pkg;

  localparam int unsigned KeyWidth    = 64;
  localparam int unsigned GroupWidth  = 16;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned ValueDigits = 16;
  localparam int unsigned TotalDigits = 20;

  // character codes that the classifier recognizes
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'
  localparam logic [7:0] ChLowA   = 8'h61;  // 'a'
  localparam logic [7:0] ChLowF   = 8'h66;  // 'f'
  localparam logic [7:0] ChUpA    = 8'h41;  // 'A'
  localparam logic [7:0] ChUpF    = 8'h46;  // 'F'
  localparam logic [7:0] ChUpO    = 8'h4f;  // 'O'
  localparam logic [7:0] ChLowO   = 8'h6f;  // 'o'
  localparam logic [7:0] ChUpI    = 8'h49;  // 'I'
  localparam logic [7:0] ChLowL   = 8'h6c;  // 'l'

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  // classified character
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
  } digit_t;

  // result produced by the core for one transaction
  typedef struct packed {
    logic                  emit;
    logic [KeyWidth-1:0]   key_value;
    status_t               status;
  } result_t;

endpackage

### rtl/rhd_classify.sv
// rhd_classify: maps one character byte to a hex digit value or "not a digit"
// depends on rhd_pkg
module rhd_classify (
  input  logic [7:0]      char_code,
  output rhd_pkg::digit_t digit_out
);
  import rhd_pkg::*;

  // hex digits of either case, plus O/o as 0 and I/l as 1
  always_comb begin
    digit_out = '{is_digit: 1'b0, digit: 4'd0};
    if (char_code >= ChZero && char_code <= ChNine) begin
      digit_out.is_digit = 1'b1;
      digit_out.digit    = 4'(char_code - ChZero);
    end else if (char_code >= ChLowA && char_code <= ChLowF) begin
      digit_out.is_digit = 1'b1;
      digit_out.digit    = 4'(char_code - ChLowA + 8'd10);
    end else if (char_code >= ChUpA && char_code <= ChUpF) begin
      digit_out.is_digit = 1'b1;
      digit_out.digit    = 4'(char_code - ChUpA + 8'd10);
    end else if (char_code == ChUpO || char_code == ChLowO) begin
      digit_out.is_digit = 1'b1;
      digit_out.digit    = 4'd0;
    end else if (char_code == ChUpI || char_code == ChLowL) begin
      digit_out.is_digit = 1'b1;
      digit_out.digit    = 4'd1;
    end
  end

endmodule

### rtl/rhd_core.sv
// rhd_core: per-string decode state, digit accumulation and check word compare
// depends on rhd_pkg and rhd_classify
module rhd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       char_code,
  input  logic             last,
  output rhd_pkg::result_t result
);
  import rhd_pkg::*;

  logic [CountWidth-1:0] digit_count, digit_count_next;
  logic [KeyWidth-1:0]   value_shift, value_shift_next;
  logic [GroupWidth-1:0] group_shift, group_shift_next;
  logic [GroupWidth-1:0] xor_accum, xor_accum_next;
  logic                  answered, answered_next;

  digit_t                digit;
  logic [GroupWidth-1:0] group_shifted;
  logic [CountWidth-1:0] count_inc;

  rhd_classify u_classify (
    .char_code (char_code),
    .digit_out (digit)
  );

  assign group_shifted = {group_shift[GroupWidth-5:0], digit.digit};
  assign count_inc     = digit_count + CountWidth'(1);

  // next state and result for the transaction in the input register
  always_comb begin
    digit_count_next = digit_count;
    value_shift_next = value_shift;
    group_shift_next = group_shift;
    xor_accum_next   = xor_accum;
    answered_next    = answered;
    result           = '{emit: 1'b0, key_value: '0, status: STATUS_OK};

    if (!answered && digit.is_digit) begin
      digit_count_next = count_inc;
      group_shift_next = group_shifted;
      if (digit_count < CountWidth'(ValueDigits)) begin
        value_shift_next = {value_shift[KeyWidth-5:0], digit.digit};
        // a finished value group folds into the check accumulator
        if (count_inc[1:0] == 2'b00) begin
          xor_accum_next   = xor_accum ^ group_shifted;
          group_shift_next = '0;
        end
      end else if (count_inc >= CountWidth'(TotalDigits)) begin
        // last check digit: compare and answer
        answered_next = 1'b1;
        result.emit   = 1'b1;
        if (group_shifted == xor_accum) begin
          result.key_value = value_shift;
          result.status    = STATUS_OK;
        end else begin
          result.status    = STATUS_MISMATCH;
        end
      end
    end

    // string ended before the answer
    if (!answered_next && last) begin
      result.emit      = 1'b1;
      result.key_value = '0;
      result.status    = STATUS_SHORT;
    end

    // end of string returns everything to zero
    if (last) begin
      digit_count_next = '0;
      value_shift_next = '0;
      group_shift_next = '0;
      xor_accum_next   = '0;
      answered_next    = 1'b0;
    end

    if (!step) begin
      result.emit = 1'b0;
    end
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      value_shift <= '0;
      group_shift <= '0;
      xor_accum   <= '0;
      answered    <= 1'b0;
    end else if (step) begin
      digit_count <= digit_count_next;
      value_shift <= value_shift_next;
      group_shift <= group_shift_next;
      xor_accum   <= xor_accum_next;
      answered    <= answered_next;
    end
  end

endmodule

### rtl/readable_hex64_decoder_top.sv
// readable_hex64_decoder_top: input register, decode core and result register
// depends on rhd_pkg and rhd_core
// result path: an accepted character's result is captured in the result register
//   when the input register moves on, which a held and stalled result can delay
// throughput: one character per cycle while the result side is not stalled; a held
//   and stalled result freezes the input register, which stalls the input once full
// reset: rst clears all decode state and both valid flags
module readable_hex64_decoder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_stall,
  input  logic [7:0]                   char_code,
  input  logic                         last,
  output logic                         key_valid,
  input  logic                         key_stall,
  output logic [rhd_pkg::KeyWidth-1:0] key_value,
  output logic [1:0]                   status
);
  import rhd_pkg::*;

  logic       in_full;
  logic [7:0] in_char;
  logic       in_last;
  logic       advance;
  logic       step;
  result_t    result;

  // the input register moves on unless a result is held and stalled
  assign advance    = !(key_valid && key_stall);
  assign step       = in_full && advance;
  assign char_stall = in_full && !advance;

  rhd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (in_char),
    .last      (in_last),
    .result    (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!char_stall) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_char <= char_code;
      in_last <= last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (advance) begin
      key_valid <= result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      key_value <= result.key_value;
      status    <= result.status;
    end
  end

endmodule
